// File: sv/rtxf_pkg.sv
// shared types, constants and the header byte table of the transmit-request framer
// no dependencies; every module imports this package
`default_nettype none

package rtxf_pkg;

  localparam logic [6:0] MAX_PAYLOAD     = 7'd100;
  localparam logic [7:0] START_DELIMITER = 8'h7E;
  localparam logic [15:0] HDR_OVERHEAD   = 16'd14;

  // header byte positions: delimiter, length, then the summed part
  localparam logic [4:0] HDR_SUM_FIRST = 5'd3;
  localparam logic [4:0] HDR_LAST      = 5'd16;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // configuration register indexes
  localparam logic [2:0] REG_FRAME_ID     = 3'd0;
  localparam logic [2:0] REG_DEST_LONG    = 3'd1;
  localparam logic [2:0] REG_DEST_SHORT   = 3'd2;
  localparam logic [2:0] REG_HOP_RADIUS   = 3'd3;
  localparam logic [2:0] REG_TX_OPTIONS   = 3'd4;
  localparam logic [2:0] REG_FRAME_TYPE   = 3'd5;

  typedef struct packed {
    logic [7:0]  frame_id;
    logic [63:0] dest_addr_long;
    logic [15:0] dest_addr_short;
    logic [7:0]  hop_radius;
    logic [7:0]  tx_option_bits;
    logic [7:0]  frame_type;
  } cfg_t;

  // one classified payload beat
  typedef struct packed {
    logic       first;
    logic       last;
    logic [6:0] len;
    logic [7:0] data;
  } q_entry_t;

  function automatic logic [7:0] hdr_byte(input logic [4:0] idx, input logic [6:0] len,
                                          input cfg_t cfg);
    logic [15:0] total;
    total = {9'd0, len} + HDR_OVERHEAD;
    case (idx)
      5'd0:    hdr_byte = START_DELIMITER;
      5'd1:    hdr_byte = total[15:8];
      5'd2:    hdr_byte = total[7:0];
      5'd3:    hdr_byte = cfg.frame_type;
      5'd4:    hdr_byte = cfg.frame_id;
      5'd5:    hdr_byte = cfg.dest_addr_long[63:56];
      5'd6:    hdr_byte = cfg.dest_addr_long[55:48];
      5'd7:    hdr_byte = cfg.dest_addr_long[47:40];
      5'd8:    hdr_byte = cfg.dest_addr_long[39:32];
      5'd9:    hdr_byte = cfg.dest_addr_long[31:24];
      5'd10:   hdr_byte = cfg.dest_addr_long[23:16];
      5'd11:   hdr_byte = cfg.dest_addr_long[15:8];
      5'd12:   hdr_byte = cfg.dest_addr_long[7:0];
      5'd13:   hdr_byte = cfg.dest_addr_short[15:8];
      5'd14:   hdr_byte = cfg.dest_addr_short[7:0];
      5'd15:   hdr_byte = cfg.hop_radius;
      5'd16:   hdr_byte = cfg.tx_option_bits;
      default: hdr_byte = 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: sv/rtxf_front.sv
// front end: accepts payload beats, clamps the length and marks first/last of frame
// depends on rtxf_pkg
`default_nettype none

module rtxf_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [7:0]         in_byte,
  input  wire logic [6:0]         in_len,
  input  wire logic               q_full,
  output logic                    in_ready,
  output logic                    push,
  output rtxf_pkg::q_entry_t      push_entry
);
  import rtxf_pkg::*;

  logic [6:0] rem_r, rem_nxt;
  logic [6:0] len_c;
  logic [6:0] rem_after;
  logic       first;

  always_comb begin
    if (in_len == 7'd0) begin
      len_c = 7'd1;
    end else if (in_len > MAX_PAYLOAD) begin
      len_c = MAX_PAYLOAD;
    end else begin
      len_c = in_len;
    end
  end

  assign first     = (rem_r == 7'd0);
  assign rem_after = first ? (len_c - 7'd1) : (rem_r - 7'd1);
  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;

  always_comb begin
    push_entry.first = first;
    push_entry.last  = (rem_after == 7'd0);
    push_entry.len   = len_c;
    push_entry.data  = in_byte;
  end

  assign rem_nxt = push ? rem_after : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 7'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/rtxf_queue.sv
// short queue of classified beats between front and back
// depends on rtxf_pkg
`default_nettype none

module rtxf_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire rtxf_pkg::q_entry_t push_entry,
  input  wire logic               pop,
  output logic                    full,
  output logic                    q_valid,
  output rtxf_pkg::q_entry_t      head
);
  import rtxf_pkg::*;

  q_entry_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem_r[rd_r];

  assign wr_nxt  = push ? wr_r + 1'b1 : wr_r;
  assign rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
  assign cnt_nxt = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// File: sv/rtxf_back.sv
// back end: header sequencer, payload pass-through, checksum and output register
// depends on rtxf_pkg
`default_nettype none

module rtxf_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rtxf_pkg::cfg_t     cfg,
  input  wire logic               q_valid,
  input  wire rtxf_pkg::q_entry_t head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_last
);
  import rtxf_pkg::*;

  localparam logic [1:0] S_PAY  = 2'd0;  // next head may open a frame
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_BODY = 2'd2;  // head is the payload byte after a header
  localparam logic [1:0] S_CSUM = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       adv;
  logic       emit;
  logic [7:0] hb;

  assign adv = !vld_r || out_ready;
  assign hb  = hdr_byte(idx_r, head.len, cfg);

  always_comb begin
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    sum_nxt  = sum_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    emit     = 1'b0;
    pop      = 1'b0;
    if (adv) begin
      case (st_r)
        S_PAY, S_BODY: begin
          if (q_valid) begin
            emit     = 1'b1;
            last_nxt = 1'b0;
            if (st_r == S_PAY && head.first) begin
              byte_nxt = START_DELIMITER;
              sum_nxt  = 8'h00;
              idx_nxt  = 5'd1;
              st_nxt   = S_HDR;
            end else begin
              pop      = 1'b1;
              byte_nxt = head.data;
              sum_nxt  = sum_r + head.data;
              st_nxt   = head.last ? S_CSUM : S_PAY;
            end
          end
        end
        S_HDR: begin
          emit     = 1'b1;
          last_nxt = 1'b0;
          byte_nxt = hb;
          if (idx_r >= HDR_SUM_FIRST) begin
            sum_nxt = sum_r + hb;
          end
          idx_nxt = idx_r + 5'd1;
          if (idx_r == HDR_LAST) begin
            st_nxt = S_BODY;
          end
        end
        S_CSUM: begin
          emit     = 1'b1;
          byte_nxt = 8'hFF - sum_r;
          last_nxt = 1'b1;
          sum_nxt  = 8'h00;
          st_nxt   = S_PAY;
        end
        default: st_nxt = S_PAY;
      endcase
    end
  end

  assign vld_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_PAY;
      idx_r <= 5'd0;
      sum_r <= 8'h00;
      vld_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      sum_r <= sum_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = vld_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

  a_hdr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_HDR |-> idx_r >= 5'd1 && idx_r <= HDR_LAST)
    else $error("header index out of range");

  a_hdr_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_HDR |-> q_valid && head.first)
    else $error("header running without a frame-opening beat at the head");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid && adv)
    else $error("pop from an empty queue or into a full output");

  a_csum_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && st_r == S_CSUM) |=> st_r == S_PAY && vld_r && last_r)
    else $error("checksum beat not marked last");

endmodule

`default_nettype wire

// File: sv/radio_api_tx_request_framer_core.sv
// top level of the transmit-request framer: configuration registers, front, queue, back
// depends on rtxf_pkg, rtxf_front, rtxf_queue, rtxf_back
`default_nettype none

// channel   | direction | handshake               | payload
// in_       | in        | in_tvalid / in_tready   | in_tdata: payload_byte, payload_length
// out_      | out       | out_tvalid / out_tready | out_tdata: out_byte; out_tlast: end_of_frame
// cfg_      | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// a pass-through beat is sent as one byte; a frame's first beat is sent as 17 header bytes
// then the byte, and a frame's last beat is followed by one extra byte for the checksum
// the back end paces the output at one byte per cycle while out_tready is high;
// the 4-entry queue takes three more beats during a header, then the input waits for the
// first byte to leave. reset is synchronous, no clearing pass;
// cfg_ready is always high. out_tready low holds the output register and fills the queue

module radio_api_tx_request_framer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] payload_byte, [14:8] payload_length, [15] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,  // end_of_frame
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import rtxf_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     q_full, push, pop, q_valid;
  q_entry_t push_entry, head;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_ID:   cfg_nxt.frame_id        = cfg_data[7:0];
        REG_DEST_LONG:  cfg_nxt.dest_addr_long  = cfg_data;
        REG_DEST_SHORT: cfg_nxt.dest_addr_short = cfg_data[15:0];
        REG_HOP_RADIUS: cfg_nxt.hop_radius      = cfg_data[7:0];
        REG_TX_OPTIONS: cfg_nxt.tx_option_bits  = cfg_data[7:0];
        REG_FRAME_TYPE: cfg_nxt.frame_type      = cfg_data[7:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_id        <= 8'h01;
      cfg_r.dest_addr_long  <= 64'h0000_0000_0000_FFFF;
      cfg_r.dest_addr_short <= 16'hFFFE;
      cfg_r.hop_radius      <= 8'h00;
      cfg_r.tx_option_bits  <= 8'h00;
      cfg_r.frame_type      <= 8'h10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rtxf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata[7:0]),
    .in_len     (in_tdata[14:8]),
    .q_full     (q_full),
    .in_ready   (in_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  rtxf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .q_valid    (q_valid),
    .head       (head)
  );

  rtxf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire
